// ===== rtl/core/sgi_pkg.sv =====
// segment intersection package: register indexes, widths and control types
// shared by the division cells, the point unit, the top level and the checker
// no dependencies
package sgi_pkg;

   localparam int COORD_BITS_DEF      = 16;
   localparam int COORD_FRAC_BITS_DEF = 4;
   localparam int FRACTION_BITS_DEF   = 16;

   localparam int EPS_BITS  = 20;
   localparam int MINF_BITS = 16;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = EPS_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PARALLEL_EPSILON = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_FRACTION     = 1'd1;

   localparam logic [EPS_BITS-1:0]  EPS_RESET  = 20'd2;
   localparam logic [MINF_BITS-1:0] MINF_RESET = 16'd6;

   // per-stage control carried along the division chain
   typedef struct packed {
      logic valid;
      logic ok;
   } sgi_ctl_type;

endpackage

// ===== rtl/core/sgi_div_cell.sv =====
// one restoring-division cell: produces one quotient bit of s and of u
// and hands remainders and the point operands on to the next cell
// depends on sgi_pkg
module sgi_div_cell #(
   parameter int REM_BITS  = 36,
   parameter int FRAC_BITS = 16,
   parameter int CRD_BITS  = 16,
   parameter int DLT_BITS  = 17
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  sgi_pkg::sgi_ctl_type        ctl_in,
   input  logic [REM_BITS-1:0]         den_in,
   input  logic [REM_BITS-1:0]         rem_s_in,
   input  logic [REM_BITS-1:0]         rem_u_in,
   input  logic [FRAC_BITS-1:0]        q_s_in,
   input  logic [FRAC_BITS-1:0]        q_u_in,
   input  logic signed [CRD_BITS-1:0]  sx_in,
   input  logic signed [CRD_BITS-1:0]  sy_in,
   input  logic signed [DLT_BITS-1:0]  ax_in,
   input  logic signed [DLT_BITS-1:0]  ay_in,
   output sgi_pkg::sgi_ctl_type        ctl_out,
   output logic [REM_BITS-1:0]         den_out,
   output logic [REM_BITS-1:0]         rem_s_out,
   output logic [REM_BITS-1:0]         rem_u_out,
   output logic [FRAC_BITS-1:0]        q_s_out,
   output logic [FRAC_BITS-1:0]        q_u_out,
   output logic signed [CRD_BITS-1:0]  sx_out,
   output logic signed [CRD_BITS-1:0]  sy_out,
   output logic signed [DLT_BITS-1:0]  ax_out,
   output logic signed [DLT_BITS-1:0]  ay_out
);
   import sgi_pkg::*;

   sgi_ctl_type                ctl_ff;
   logic [REM_BITS-1:0]        den_ff, rem_s_ff, rem_u_ff, rem_s_in2, rem_u_in2;
   logic [FRAC_BITS-1:0]       q_s_ff, q_u_ff;
   logic signed [CRD_BITS-1:0] sx_ff, sy_ff;
   logic signed [DLT_BITS-1:0] ax_ff, ay_ff;
   logic [REM_BITS-1:0]        sh_s, sh_u;
   logic                       bit_s, bit_u;

   always_comb begin
      sh_s  = {rem_s_in[REM_BITS-2:0], 1'b0};
      sh_u  = {rem_u_in[REM_BITS-2:0], 1'b0};
      bit_s = (sh_s >= den_in);
      bit_u = (sh_u >= den_in);
      rem_s_in2 = bit_s ? (sh_s - den_in) : sh_s;
      rem_u_in2 = bit_u ? (sh_u - den_in) : sh_u;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff   <= den_in;
         rem_s_ff <= rem_s_in2;
         rem_u_ff <= rem_u_in2;
         q_s_ff   <= {q_s_in[FRAC_BITS-2:0], bit_s};
         q_u_ff   <= {q_u_in[FRAC_BITS-2:0], bit_u};
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
      end
   end

   assign ctl_out   = ctl_ff;
   assign den_out   = den_ff;
   assign rem_s_out = rem_s_ff;
   assign rem_u_out = rem_u_ff;
   assign q_s_out   = q_s_ff;
   assign q_u_out   = q_u_ff;
   assign sx_out    = sx_ff;
   assign sy_out    = sy_ff;
   assign ax_out    = ax_ff;
   assign ay_out    = ay_ff;

endmodule

// ===== rtl/core/sgi_point.sv =====
// point coordinate unit: start + delta*s rounded half away from zero, saturated
// two register stages: product, then rounded coordinate (zero on miss)
// depends on sgi_pkg
module sgi_point #(
   parameter int CRD_BITS  = 16,
   parameter int DLT_BITS  = 17,
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic                       keep,
   input  logic signed [CRD_BITS-1:0] start,
   input  logic signed [DLT_BITS-1:0] delta,
   input  logic [FRAC_BITS-1:0]       frac,
   output logic signed [CRD_BITS-1:0] coord
);
   import sgi_pkg::*;

   localparam int PW = DLT_BITS + FRAC_BITS + 1;
   localparam int VW = PW + 2;

   logic signed [PW-1:0]       prod_ff;
   logic signed [CRD_BITS-1:0] start_ff;
   logic                       keep_ff;
   logic signed [CRD_BITS-1:0] coord_ff, coord_in;
   logic [PW-1:0]              mag;
   logic [PW:0]                rnd;
   logic signed [VW-1:0]       val;
   logic signed [VW-1:0]       hi_lim, lo_lim;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= PW'(delta * $signed({1'b0, frac}));
         start_ff <= start;
         keep_ff  <= keep;
      end
   end

   always_comb begin
      mag    = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
      rnd    = ({1'b0, mag} + ((PW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      val    = VW'(start_ff) + (prod_ff[PW-1] ? -$signed(VW'(rnd)) : $signed(VW'(rnd)));
      hi_lim = VW'((VW'(1) << (CRD_BITS - 1)) - VW'(1));
      lo_lim = -hi_lim - VW'(1);
      if (!keep_ff) begin
         coord_in = '0;
      end else if (val > hi_lim) begin
         coord_in = hi_lim[CRD_BITS-1:0];
      end else if (val < lo_lim) begin
         coord_in = lo_lim[CRD_BITS-1:0];
      end else begin
         coord_in = val[CRD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

// ===== rtl/core/segment_intersection.sv =====
// segment intersection top level: deltas, cross products, division chain, point
// depends on sgi_pkg, sgi_div_cell, sgi_point
//
// Takes one segment pair per cycle while req_stall is low and returns one result
// transaction for each, after the stages in order: the deltas, the products, the
// cross products (the parallel and range checks feed the first cell directly),
// one cell per quotient bit of s and u, and the point multiply and round.
// Every stage moves together; req_stall is high only while a finished result is
// held by rsp_stall. Write the two registers only while the block is empty.
module segment_intersection #(
   parameter int COORD_BITS      = sgi_pkg::COORD_BITS_DEF,
   parameter int COORD_FRAC_BITS = sgi_pkg::COORD_FRAC_BITS_DEF,
   parameter int FRACTION_BITS   = sgi_pkg::FRACTION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_seg_a_start_x,
   input  logic signed [COORD_BITS-1:0]          req_seg_a_start_y,
   input  logic signed [COORD_BITS-1:0]          req_seg_a_end_x,
   input  logic signed [COORD_BITS-1:0]          req_seg_a_end_y,
   input  logic signed [COORD_BITS-1:0]          req_seg_b_start_x,
   input  logic signed [COORD_BITS-1:0]          req_seg_b_start_y,
   input  logic signed [COORD_BITS-1:0]          req_seg_b_end_x,
   input  logic signed [COORD_BITS-1:0]          req_seg_b_end_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [FRACTION_BITS-1:0]              rsp_fraction_along_a,
   output logic signed [COORD_BITS-1:0]          rsp_cross_x,
   output logic signed [COORD_BITS-1:0]          rsp_cross_y,
   input  logic                                  csr_write,
   input  logic [sgi_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sgi_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import sgi_pkg::*;

   // binary point position does not change the integer arithmetic
   localparam int FRAC_POS = COORD_FRAC_BITS;
   localparam int D   = COORD_BITS + 1;
   localparam int PB  = 2 * D;
   localparam int C   = PB + 1;
   localparam int R   = C + 1;
   localparam int F   = FRACTION_BITS;
   localparam int EW  = (C > EPS_BITS) ? C : EPS_BITS;
   localparam int MW  = (F > MINF_BITS) ? F : MINF_BITS;

   logic adv;
   logic [EPS_BITS-1:0]  eps_ff;
   logic [MINF_BITS-1:0] minf_ff;

   // stage 1: deltas
   logic                   v1_ff;
   logic signed [COORD_BITS-1:0] sx1_ff, sy1_ff;
   logic signed [D-1:0]    ax1_ff, ay1_ff, bx1_ff, by1_ff, dx1_ff, dy1_ff;
   // stage 2: products
   logic                   v2_ff;
   logic signed [COORD_BITS-1:0] sx2_ff, sy2_ff;
   logic signed [D-1:0]    ax2_ff, ay2_ff;
   logic signed [PB-1:0]   p_axby_ff, p_aybx_ff, p_dxby_ff, p_dybx_ff, p_dxay_ff, p_dyax_ff;
   // stage 3: cross products
   logic                   v3_ff;
   logic signed [COORD_BITS-1:0] sx3_ff, sy3_ff;
   logic signed [D-1:0]    ax3_ff, ay3_ff;
   logic signed [C-1:0]    c3_ff, ns3_ff, nu3_ff;
   // checks
   logic [C-1:0]           abs_c, abs_s, abs_u;
   logic                   par, ok_s, ok_u;
   sgi_ctl_type            ctl0;

   // chain
   sgi_ctl_type            ctl_ch [0:F];
   logic [R-1:0]           den_ch [0:F];
   logic [R-1:0]           rs_ch  [0:F];
   logic [R-1:0]           ru_ch  [0:F];
   logic [F-1:0]           qs_ch  [0:F];
   logic [F-1:0]           qu_ch  [0:F];
   logic signed [COORD_BITS-1:0] sx_ch [0:F];
   logic signed [COORD_BITS-1:0] sy_ch [0:F];
   logic signed [D-1:0]    ax_ch  [0:F];
   logic signed [D-1:0]    ay_ch  [0:F];

   logic                   hit_last;
   logic                   v5_ff, hit5_ff;
   logic [F-1:0]           frac5_ff;
   logic                   rsp_valid_ff, rsp_hit_ff;
   logic [F-1:0]           rsp_frac_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff  <= EPS_RESET;
         minf_ff <= MINF_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PARALLEL_EPSILON: eps_ff  <= csr_data[EPS_BITS-1:0];
            CSR_MIN_FRACTION:     minf_ff <= csr_data[MINF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v5_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v5_ff <= ctl_ch[F].valid;
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx1_ff <= req_seg_a_start_x;
         sy1_ff <= req_seg_a_start_y;
         ax1_ff <= D'(req_seg_a_end_x) - D'(req_seg_a_start_x);
         ay1_ff <= D'(req_seg_a_end_y) - D'(req_seg_a_start_y);
         bx1_ff <= D'(req_seg_b_end_x) - D'(req_seg_b_start_x);
         by1_ff <= D'(req_seg_b_end_y) - D'(req_seg_b_start_y);
         dx1_ff <= D'(req_seg_b_start_x) - D'(req_seg_a_start_x);
         dy1_ff <= D'(req_seg_b_start_y) - D'(req_seg_a_start_y);

         sx2_ff    <= sx1_ff;
         sy2_ff    <= sy1_ff;
         ax2_ff    <= ax1_ff;
         ay2_ff    <= ay1_ff;
         p_axby_ff <= PB'(ax1_ff * by1_ff);
         p_aybx_ff <= PB'(ay1_ff * bx1_ff);
         p_dxby_ff <= PB'(dx1_ff * by1_ff);
         p_dybx_ff <= PB'(dy1_ff * bx1_ff);
         p_dxay_ff <= PB'(dx1_ff * ay1_ff);
         p_dyax_ff <= PB'(dy1_ff * ax1_ff);

         sx3_ff <= sx2_ff;
         sy3_ff <= sy2_ff;
         ax3_ff <= ax2_ff;
         ay3_ff <= ay2_ff;
         c3_ff  <= C'(p_axby_ff) - C'(p_aybx_ff);
         ns3_ff <= C'(p_dxby_ff) - C'(p_dybx_ff);
         nu3_ff <= C'(p_dxay_ff) - C'(p_dyax_ff);
      end
   end

   always_comb begin
      abs_c = c3_ff[C-1]  ? C'(-c3_ff)  : C'(c3_ff);
      abs_s = ns3_ff[C-1] ? C'(-ns3_ff) : C'(ns3_ff);
      abs_u = nu3_ff[C-1] ? C'(-nu3_ff) : C'(nu3_ff);
      par   = (EW'(abs_c) <= EW'(eps_ff));
      ok_s  = ((ns3_ff == '0) || (ns3_ff[C-1] == c3_ff[C-1])) && (abs_s < abs_c);
      ok_u  = ((nu3_ff == '0) || (nu3_ff[C-1] == c3_ff[C-1])) && (abs_u < abs_c);
      ctl0.valid = v3_ff;
      ctl0.ok    = !par && ok_s && ok_u;
   end

   assign ctl_ch[0] = ctl0;
   assign den_ch[0] = R'(abs_c);
   assign rs_ch[0]  = R'(abs_s);
   assign ru_ch[0]  = R'(abs_u);
   assign qs_ch[0]  = '0;
   assign qu_ch[0]  = '0;
   assign sx_ch[0]  = sx3_ff;
   assign sy_ch[0]  = sy3_ff;
   assign ax_ch[0]  = ax3_ff;
   assign ay_ch[0]  = ay3_ff;

   for (genvar i = 0; i < F; i++) begin : g_cell
      sgi_div_cell #(
         .REM_BITS  (R),
         .FRAC_BITS (F),
         .CRD_BITS  (COORD_BITS),
         .DLT_BITS  (D)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .ctl_in    (ctl_ch[i]),
         .den_in    (den_ch[i]),
         .rem_s_in  (rs_ch[i]),
         .rem_u_in  (ru_ch[i]),
         .q_s_in    (qs_ch[i]),
         .q_u_in    (qu_ch[i]),
         .sx_in     (sx_ch[i]),
         .sy_in     (sy_ch[i]),
         .ax_in     (ax_ch[i]),
         .ay_in     (ay_ch[i]),
         .ctl_out   (ctl_ch[i+1]),
         .den_out   (den_ch[i+1]),
         .rem_s_out (rs_ch[i+1]),
         .rem_u_out (ru_ch[i+1]),
         .q_s_out   (qs_ch[i+1]),
         .q_u_out   (qu_ch[i+1]),
         .sx_out    (sx_ch[i+1]),
         .sy_out    (sy_ch[i+1]),
         .ax_out    (ax_ch[i+1]),
         .ay_out    (ay_ch[i+1])
      );
   end

   assign hit_last = ctl_ch[F].ok && (MW'(qs_ch[F]) > MW'(minf_ff))
                     && (MW'(qu_ch[F]) > MW'(minf_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         hit5_ff     <= hit_last;
         frac5_ff    <= hit_last ? qs_ch[F] : '0;
         rsp_hit_ff  <= hit5_ff;
         rsp_frac_ff <= frac5_ff;
      end
   end

   sgi_point #(.CRD_BITS(COORD_BITS), .DLT_BITS(D), .FRAC_BITS(F)) u_point_x (
      .clock (clock),
      .en    (adv),
      .keep  (hit_last),
      .start (sx_ch[F]),
      .delta (ax_ch[F]),
      .frac  (qs_ch[F]),
      .coord (rsp_cross_x)
   );

   sgi_point #(.CRD_BITS(COORD_BITS), .DLT_BITS(D), .FRAC_BITS(F)) u_point_y (
      .clock (clock),
      .en    (adv),
      .keep  (hit_last),
      .start (sy_ch[F]),
      .delta (ay_ch[F]),
      .frac  (qs_ch[F]),
      .coord (rsp_cross_y)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_fraction_along_a = (FRAC_POS >= 0) ? rsp_frac_ff : '0;

endmodule

// ===== rtl/core/sgi_checker.sv =====
// port-level checker for segment_intersection, attached by bind
// depends on sgi_pkg
module sgi_checker #(
   parameter int COORD_BITS    = sgi_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = sgi_pkg::FRACTION_BITS_DEF
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_hit,
   input logic [FRACTION_BITS-1:0] rsp_fraction_along_a,
   input logic [COORD_BITS-1:0]    rsp_cross_x,
   input logic [COORD_BITS-1:0]    rsp_cross_y
);
   import sgi_pkg::*;

   // input side only backs up behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a held result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hit)
         && $stable(rsp_fraction_along_a) && $stable(rsp_cross_x)))
      else $error("result transaction changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_fraction_along_a == '0
         && rsp_cross_x == '0 && rsp_cross_y == '0))
      else $error("miss with nonzero fields");

   a_hit_frac: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_fraction_along_a != '0))
      else $error("hit with zero fraction");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind segment_intersection sgi_checker #(
   .COORD_BITS    (COORD_BITS),
   .FRACTION_BITS (FRACTION_BITS)
) u_sgi_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_hit              (rsp_hit),
   .rsp_fraction_along_a (rsp_fraction_along_a),
   .rsp_cross_x          (rsp_cross_x),
   .rsp_cross_y          (rsp_cross_y)
);
